// File: sv/plc_pkg.sv
// Package: shared types and constants for the password lock command controller.
`timescale 1ns / 1ps
`default_nettype none
package plc_pkg;

  localparam logic [7:0] CMD_SET_PASS   = 8'hF0;
  localparam logic [7:0] CMD_CONFIRM    = 8'h0F;
  localparam logic [7:0] CMD_ALARM_ON   = 8'h8A;
  localparam logic [7:0] CMD_ALARM_OFF  = 8'hA8;
  localparam logic [7:0] CMD_DOOR_OPEN  = 8'hDB;
  localparam logic [7:0] CMD_DOOR_CLOSE = 8'hBD;

  localparam logic [15:0] RUN_TICKS_RESET = 16'd15000;

  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_SET     = 2'd1;
  localparam logic [1:0] PH_CONFIRM = 2'd2;

  localparam logic [1:0] DIR_FORWARD = 2'b01;
  localparam logic [1:0] DIR_REVERSE = 2'b10;

  // One result item as it leaves the core.
  typedef struct packed {
    logic motor_enable;
    logic motor_reverse;
    logic motor_forward;
    logic buzzer_on;
    logic reply_match;
    logic reply_valid;
  } plc_result_t;

endpackage
`default_nettype wire

// File: sv/plc_core.sv
// Command decoder, password store and motor timer; forms the result of each accepted item.
`timescale 1ns / 1ps
`default_nettype none
module plc_core
  import plc_pkg::*;
#(
  parameter int PASS_LEN = 5
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        accept,
  input  wire logic        is_tick,
  input  wire logic [7:0]  rx_byte,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata,
  output plc_result_t      result
);

  localparam int IDX_W = (PASS_LEN > 1) ? $clog2(PASS_LEN) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PASS_LEN - 1);

  logic [15:0]      motor_run_ticks;
  logic [1:0]       phase, phase_next;
  logic [IDX_W-1:0] byte_index, byte_index_next;
  logic [7:0]       password_store [PASS_LEN];
  logic             mismatch_seen, mismatch_seen_next;
  logic             buzzer_level, buzzer_level_next;
  logic [1:0]       direction_lines, direction_lines_next;
  logic [15:0]      motor_ticks_left, motor_ticks_left_next;
  logic             store_we;
  logic             byte_differs;

  assign byte_differs = (password_store[byte_index] != rx_byte);

  always_comb begin
    phase_next            = phase;
    byte_index_next       = byte_index;
    mismatch_seen_next    = mismatch_seen;
    buzzer_level_next     = buzzer_level;
    direction_lines_next  = direction_lines;
    motor_ticks_left_next = motor_ticks_left;
    store_we              = 1'b0;
    result                = '0;

    if (is_tick) begin
      if (motor_ticks_left != 16'd0) begin
        motor_ticks_left_next = motor_ticks_left - 16'd1;
      end
    end else if (motor_ticks_left == 16'd0) begin
      if (phase inside {PH_SET, PH_CONFIRM}) begin
        if (phase == PH_SET) begin
          store_we = 1'b1;
        end else if (byte_differs) begin
          mismatch_seen_next = 1'b1;
        end
        if (byte_index == LAST_IDX) begin
          if (phase == PH_CONFIRM) begin
            result.reply_valid = 1'b1;
            result.reply_match = !(mismatch_seen || byte_differs);
          end
          phase_next      = PH_IDLE;
          byte_index_next = '0;
        end else begin
          byte_index_next = byte_index + IDX_W'(1);
        end
      end else begin
        // Idle, or the unused phase code: read the byte as a command.
        phase_next = PH_IDLE;
        case (rx_byte)
          CMD_SET_PASS: begin
            phase_next      = PH_SET;
            byte_index_next = '0;
          end
          CMD_CONFIRM: begin
            phase_next         = PH_CONFIRM;
            byte_index_next    = '0;
            mismatch_seen_next = 1'b0;
          end
          CMD_ALARM_ON:  buzzer_level_next = 1'b1;
          CMD_ALARM_OFF: buzzer_level_next = 1'b0;
          CMD_DOOR_OPEN: begin
            direction_lines_next  = DIR_FORWARD;
            motor_ticks_left_next = motor_run_ticks;
          end
          CMD_DOOR_CLOSE: begin
            direction_lines_next  = DIR_REVERSE;
            motor_ticks_left_next = motor_run_ticks;
          end
          default: ;
        endcase
      end
    end

    result.buzzer_on     = buzzer_level_next;
    result.motor_forward = direction_lines_next[0];
    result.motor_reverse = direction_lines_next[1];
    result.motor_enable  = (motor_ticks_left_next != 16'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      motor_run_ticks <= RUN_TICKS_RESET;
    end else if (cfg_we) begin
      motor_run_ticks <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      byte_index       <= '0;
      mismatch_seen    <= 1'b0;
      buzzer_level     <= 1'b0;
      direction_lines  <= 2'b00;
      motor_ticks_left <= 16'd0;
      for (int i = 0; i < PASS_LEN; i++) begin
        password_store[i] <= 8'd0;
      end
    end else if (accept) begin
      phase            <= phase_next;
      byte_index       <= byte_index_next;
      mismatch_seen    <= mismatch_seen_next;
      buzzer_level     <= buzzer_level_next;
      direction_lines  <= direction_lines_next;
      motor_ticks_left <= motor_ticks_left_next;
      if (store_we) begin
        password_store[byte_index] <= rx_byte;
      end
    end
  end

endmodule
`default_nettype wire

// File: sv/password_lock_command_controller.sv
// Each accepted result is registered in main_res, or in skid_res while m_axis stalls.
// Throughput: one item per cycle; a two-entry output buffer keeps s_axis_tready high
// while one result waits, so a stall costs no input cycle until the buffer fills.
// Reset (rst, synchronous): idle phase, password store all zero, buzzer and motor off,
// run ticks back to 15000, output buffer empty.
`timescale 1ns / 1ps
`default_nettype none
module password_lock_command_controller
  import plc_pkg::*;
#(
  parameter int PASS_LEN = 5
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,  // rx_byte
  input  wire logic [0:0]  s_axis_tuser,  // command (1 = timer tick)
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // reply_valid, reply_match, buzzer_on, motor_forward, motor_reverse, motor_enable, 2 zero
  output logic [7:0]       m_axis_tdata,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata
);

  plc_result_t res;
  plc_result_t main_res;
  plc_result_t skid_res;
  logic        main_valid;
  logic        skid_valid;
  logic        in_fire;
  logic        out_fire;

  assign s_axis_tready = !skid_valid;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_fire      = main_valid && m_axis_tready;

  plc_core #(
    .PASS_LEN(PASS_LEN)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .accept   (in_fire),
    .is_tick  (s_axis_tuser[0]),
    .rx_byte  (s_axis_tdata),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .result   (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_fire) begin
        skid_valid <= 1'b0;
      end
    end else if (in_fire) begin
      if (main_valid && !out_fire) begin
        skid_valid <= 1'b1;
      end
      main_valid <= 1'b1;
    end else if (out_fire) begin
      main_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_fire) begin
        main_res <= skid_res;
      end
    end else if (in_fire) begin
      // Park the item in the skid stage while the output is stalled.
      if (main_valid && !out_fire) begin
        skid_res <= res;
      end else begin
        main_res <= res;
      end
    end
  end

  assign m_axis_tvalid = main_valid;
  assign m_axis_tdata  = {2'b00, main_res.motor_enable, main_res.motor_reverse,
                          main_res.motor_forward, main_res.buzzer_on,
                          main_res.reply_match, main_res.reply_valid};

  a_skid_needs_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> main_valid)
    else $error("skid stage holds an item while the output stage is empty");

  a_match_needs_reply: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[1]) |-> m_axis_tdata[0])
    else $error("reply_match set without reply_valid");

  a_one_direction: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tdata[3] && m_axis_tdata[4]))
    else $error("both motor direction lines high");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (m_axis_tvalid && $past(m_axis_tvalid)))
    else $error("input stalled without a waiting result");

endmodule
`default_nettype wire

// File: test/lock_result_checker.sv
// Checker: predicts each result item of the password lock controller and compares it.
`timescale 1ns / 1ps
`default_nettype none
module lock_result_checker
  import plc_pkg::*;
#(
  parameter int PASS_LEN = 5
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,
  input  wire logic [0:0]  s_axis_tuser,
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic [7:0]  m_axis_tdata,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata,
  output int               fail_count,
  output int               results_pending,
  output int               results_seen,
  output int               replies_seen,
  output int               replies_matched,
  output int               ticks_run_down
);

  logic [15:0] run_ticks;
  logic [1:0]  lock_phase;
  logic [3:0]  byte_idx;
  logic [7:0]  pass_store [PASS_LEN];
  logic        mismatch;
  logic        buzzer;
  logic [1:0]  dir_lines;
  logic [15:0] ticks_left;

  plc_result_t expected_levels [$];

  // Apply one item to the lock state and return the levels it leaves behind.
  task automatic advance_lock(input logic is_tick, input logic [7:0] rx,
                              output plc_result_t res);
    logic [3:0] idx;
    res = '0;
    if (is_tick) begin
      if (ticks_left != 0) begin
        ticks_left = ticks_left - 16'd1;
        ticks_run_down++;
      end
    end else if (ticks_left == 0) begin
      if (lock_phase == PH_SET || lock_phase == PH_CONFIRM) begin
        idx = (byte_idx >= PASS_LEN) ? 4'd0 : byte_idx;
        if (lock_phase == PH_SET) begin
          pass_store[idx] = rx;
        end else if (pass_store[idx] != rx) begin
          mismatch = 1'b1;
        end
        if (int'(idx) + 1 >= PASS_LEN) begin
          if (lock_phase == PH_CONFIRM) begin
            res.reply_valid = 1'b1;
            res.reply_match = !mismatch;
          end
          lock_phase = PH_IDLE;
          byte_idx = '0;
        end else begin
          byte_idx = idx + 4'd1;
        end
      end else begin
        lock_phase = PH_IDLE;
        case (rx)
          CMD_SET_PASS: begin
            lock_phase = PH_SET;
            byte_idx = '0;
          end
          CMD_CONFIRM: begin
            lock_phase = PH_CONFIRM;
            byte_idx = '0;
            mismatch = 1'b0;
          end
          CMD_ALARM_ON:  buzzer = 1'b1;
          CMD_ALARM_OFF: buzzer = 1'b0;
          CMD_DOOR_OPEN: begin
            dir_lines = DIR_FORWARD;
            ticks_left = run_ticks;
          end
          CMD_DOOR_CLOSE: begin
            dir_lines = DIR_REVERSE;
            ticks_left = run_ticks;
          end
          default: ;
        endcase
      end
    end
    res.buzzer_on     = buzzer;
    res.motor_forward = dir_lines[0];
    res.motor_reverse = dir_lines[1];
    res.motor_enable  = (ticks_left != 0);
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    plc_result_t want;
    plc_result_t got;
    if (rst) begin
      run_ticks = RUN_TICKS_RESET;
      lock_phase = PH_IDLE;
      byte_idx = '0;
      for (int i = 0; i < PASS_LEN; i++) pass_store[i] = '0;
      mismatch = 1'b0;
      buzzer = 1'b0;
      dir_lines = '0;
      ticks_left = '0;
      expected_levels.delete();
      fail_count = 0;
      results_seen = 0;
      replies_seen = 0;
      replies_matched = 0;
      ticks_run_down = 0;
    end else begin
      if (cfg_we) run_ticks = cfg_wdata;
      // Compare before queuing this edge's item so a stray result cannot hide behind it.
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        got = m_axis_tdata[5:0];
        if (expected_levels.size() == 0) begin
          $error("result item with nothing expected: tdata %0h", m_axis_tdata);
          fail_count++;
        end else begin
          want = expected_levels.pop_front();
          check_field("reply_valid", 8'(want.reply_valid), 8'(got.reply_valid));
          check_field("reply_match", 8'(want.reply_match), 8'(got.reply_match));
          check_field("buzzer_on", 8'(want.buzzer_on), 8'(got.buzzer_on));
          check_field("motor_forward", 8'(want.motor_forward), 8'(got.motor_forward));
          check_field("motor_reverse", 8'(want.motor_reverse), 8'(got.motor_reverse));
          check_field("motor_enable", 8'(want.motor_enable), 8'(got.motor_enable));
          check_field("tdata pad", 8'd0, 8'(m_axis_tdata[7:6]));
          if (want.reply_valid) begin
            replies_seen++;
            if (want.reply_match) replies_matched++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        advance_lock(s_axis_tuser[0], s_axis_tdata, want);
        expected_levels.push_back(want);
      end
    end
    results_pending = expected_levels.size();
  end

endmodule
`default_nettype wire

// File: test/tb_password_lock_command_controller.sv
// Testbench top: drives commands, ticks and register writes into the lock controller.
`timescale 1ns / 1ps
`default_nettype none
module tb_password_lock_command_controller
  import plc_pkg::*;
();

  localparam int PASS_LEN = 5;

  typedef logic [PASS_LEN-1:0][7:0] pass_word_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // rx_byte
  logic [0:0]  s_axis_tuser;   // command (1 = timer tick)
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // reply_valid, reply_match, buzzer_on, motor_forward, motor_reverse, motor_enable, 2 zero
  logic [7:0]  m_axis_tdata;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  int fail_count;
  int results_pending;
  int results_seen;
  int replies_seen;
  int replies_matched;
  int ticks_run_down;

  bit          quiet;
  int          live_items;
  logic [15:0] run_ticks_now;
  pass_word_t  pass_now;
  logic [7:0]  cmd_codes [6] = '{CMD_SET_PASS, CMD_CONFIRM, CMD_ALARM_ON, CMD_ALARM_OFF,
                                  CMD_DOOR_OPEN, CMD_DOOR_CLOSE};

  password_lock_command_controller #(
    .PASS_LEN(PASS_LEN)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  lock_result_checker #(
    .PASS_LEN(PASS_LEN)
  ) i_checker (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .fail_count(fail_count),
    .results_pending(results_pending),
    .results_seen(results_seen),
    .replies_seen(replies_seen),
    .replies_matched(replies_matched),
    .ticks_run_down(ticks_run_down)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #100ms;
    $display("simulation failed");
    $finish;
  end

  // Receiver stalls in random bursts until the quiet tail of the run.
  initial begin
    m_axis_tready <= 1'b1;
    forever begin
      @(posedge clk);
      if (!rst && !quiet && $urandom_range(0, 9) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        m_axis_tready <= 1'b1;
      end
    end
  end

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 3))
      0:       return cmd_codes[$urandom_range(0, 5)];
      1:       return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      default: return 8'($urandom);
    endcase
  endfunction

  // Hold the item until it is taken; maybe idle a burst first.
  task automatic push_item(input logic is_tick, input logic [7:0] rx);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= is_tick;
    s_axis_tdata  <= rx;
    do @(posedge clk); while (!s_axis_tready);
    live_items++;
  endtask

  // Stop sending and wait until every result item has come back.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk); while (results_pending != 0);
    @(posedge clk);
  endtask

  task automatic write_run_ticks(input logic [15:0] value);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    run_ticks_now = value;
  endtask

  // Command byte plus one password word; idle ticks may fall between bytes.
  task automatic send_capture(input logic [7:0] cmd, input pass_word_t word,
                              input bit tick_inside);
    push_item(1'b0, cmd);
    for (int i = 0; i < PASS_LEN; i++) begin
      if ((tick_inside && i == 2) || $urandom_range(0, 7) == 0) push_item(1'b1, 8'($urandom));
      push_item(1'b0, word[i]);
    end
  endtask

  task automatic send_confirm(input bit spoil);
    pass_word_t word;
    word = pass_now;
    if (spoil) word[$urandom_range(0, PASS_LEN - 1)] ^= 8'($urandom_range(1, 255));
    send_capture(CMD_CONFIRM, word, 1'b0);
  endtask

  // Door command, then enough ticks to stop the motor; bytes sent while it runs are dropped.
  task automatic run_door(input logic [7:0] cmd);
    push_item(1'b0, cmd);
    for (int i = 0; i < run_ticks_now; i++) begin
      if ($urandom_range(0, 5) == 0) push_item(1'b0, 8'($urandom));
      push_item(1'b1, 8'($urandom));
    end
    repeat ($urandom_range(0, 2)) push_item(1'b1, 8'($urandom));
  endtask

  initial begin
    pass_word_t word;
    logic [7:0] noise;
    int         next_cfg_at;

    quiet = 1'b0;
    live_items = 0;
    run_ticks_now = RUN_TICKS_RESET;
    pass_now = '0;
    rst <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= '0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: idle ticks, unknown bytes, alarm, capture paths, door runs.
    push_item(1'b1, 8'h55);
    push_item(1'b0, 8'h00);
    push_item(1'b0, 8'hFF);
    push_item(1'b0, CMD_ALARM_ON);
    push_item(1'b0, CMD_ALARM_ON);
    push_item(1'b0, CMD_ALARM_OFF);
    send_capture(CMD_CONFIRM, pass_now, 1'b0);
    word = {8'hFF, 8'h00, 8'h5A, 8'hA5, 8'hDB};
    send_capture(CMD_SET_PASS, word, 1'b1);
    pass_now = word;
    send_capture(CMD_CONFIRM, pass_now, 1'b1);
    word[PASS_LEN-1] ^= 8'h01;
    send_capture(CMD_CONFIRM, word, 1'b0);
    write_run_ticks(16'd4);
    run_door(CMD_DOOR_OPEN);

    // Zero run count: direction changes, enable stays low.
    write_run_ticks(16'd0);
    push_item(1'b0, CMD_DOOR_CLOSE);
    push_item(1'b0, CMD_DOOR_OPEN);
    push_item(1'b0, CMD_ALARM_ON);
    push_item(1'b0, CMD_DOOR_CLOSE);
    push_item(1'b1, 8'hAA);
    write_run_ticks(16'd9);
    run_door(CMD_DOOR_CLOSE);
    write_run_ticks(16'd1);
    run_door(CMD_DOOR_OPEN);
    run_door(CMD_DOOR_OPEN);

    // Random: mostly well-formed command sequences, some noise and spoiled confirms.
    next_cfg_at = live_items;
    while (live_items < 450) begin
      if (live_items >= next_cfg_at) begin
        case ($urandom_range(0, 3))
          0:       write_run_ticks(16'd0);
          1:       write_run_ticks(16'd1);
          default: write_run_ticks(16'($urandom_range(2, 20)));
        endcase
        next_cfg_at += 90;
      end
      if (live_items >= 410) quiet = 1'b1;
      case ($urandom_range(0, 11))
        0, 1: begin
          for (int i = 0; i < PASS_LEN; i++) word[i] = pick_byte();
          send_capture(CMD_SET_PASS, word, 1'b0);
          pass_now = word;
        end
        2, 3, 4, 5: send_confirm($urandom_range(0, 2) == 0);
        6: begin
          push_item(1'b0, $urandom_range(0, 1) ? CMD_ALARM_ON : CMD_ALARM_OFF);
        end
        7: run_door($urandom_range(0, 1) ? CMD_DOOR_OPEN : CMD_DOOR_CLOSE);
        8: begin
          // Keep noise from opening a capture or a door run the sequencer does not track.
          do noise = 8'($urandom);
          while (noise == CMD_SET_PASS || noise == CMD_CONFIRM ||
                 noise == CMD_DOOR_OPEN || noise == CMD_DOOR_CLOSE);
          push_item(1'b0, noise);
        end
        9: push_item(1'b1, 8'($urandom));
        10: if ($urandom_range(0, 3) == 0) drain();
        default: send_confirm(1'b0);
      endcase
    end

    quiet = 1'b1;
    drain();
    repeat (5) @(posedge clk);
    $display("Sent %0d items; checked %0d result items: %0d confirm replies, %0d matching.",
             live_items, results_seen, replies_seen, replies_matched);
    $display("Motor ran down %0d ticks over run counts 0, 1 and small values.",
             ticks_run_down);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
